FILE: src/wtsc_pkg.sv
// package: shared constants, command codes, control struct and period helper
`default_nettype none

package wtsc_pkg;

   localparam int WAVE_ENTRIES = 32;
   localparam int POS_W        = $clog2(WAVE_ENTRIES);

   // item command codes
   localparam logic [2:0] CMD_REG_WRITE = 3'd0;
   localparam logic [2:0] CMD_CYCLES    = 3'd1;
   localparam logic [2:0] CMD_LENGTH    = 3'd2;
   localparam logic [2:0] CMD_RAM_WRITE = 3'd3;
   localparam logic [2:0] CMD_POS_RESET = 3'd4;

   // channel register indexes
   localparam logic [2:0] REG_DAC     = 3'd0;
   localparam logic [2:0] REG_LENGTH  = 3'd1;
   localparam logic [2:0] REG_VOLUME  = 3'd2;
   localparam logic [2:0] REG_FREQ_LO = 3'd3;
   localparam logic [2:0] REG_FREQ_HI = 3'd4;

   localparam logic [12:0] DIV_RESET  = 13'd4096;
   localparam logic [2:0]  VOL_MUTED  = 3'd4;
   localparam logic [8:0]  LEN_FULL   = 9'd256;

   // controller to datapath commands
   typedef struct packed {
      logic apply;    // perform the single-cycle part of the accepted item
      logic step;     // advance the divider by one input clock
      logic capture;  // load the result register
   } ctl_cmd_type;

   // divider period (2048 - f) * 2, written as 4096 - 2f
   function automatic logic [12:0] period_of(input logic [10:0] freq);
      period_of = DIV_RESET - {1'b0, freq, 1'b0};
   endfunction

endpackage

`default_nettype wire

FILE: src/wtsc_ifs.sv
// interfaces: request and response channels with valid/ready handshake
`default_nettype none

interface wtsc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] command;
   logic [2:0] reg_select;
   logic [7:0] write_data;
   logic [3:0] cycle_count;
   logic [4:0] ram_index;
   logic [3:0] ram_sample;

   modport source (output valid, command, reg_select, write_data, cycle_count,
                   ram_index, ram_sample, input ready);
   modport sink   (input valid, command, reg_select, write_data, cycle_count,
                   ram_index, ram_sample, output ready);
endinterface

interface wtsc_rsp_if;
   logic       valid;
   logic       ready;
   logic [3:0] sample_out;
   logic       channel_enabled;

   modport source (output valid, sample_out, channel_enabled, input ready);
   modport sink   (input valid, sample_out, channel_enabled, output ready);
endinterface

`default_nettype wire

FILE: src/wtsc_ctrl.sv
// controller: item sequencing, cycle step counter and result register valid
`default_nettype none

module wtsc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic [2:0]           req_command,
   input  logic [3:0]           req_cycles,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output wtsc_pkg::ctl_cmd_type cmd
);
   import wtsc_pkg::*;

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_RUN  = 2'd1;
   localparam logic [1:0] ST_DONE = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.apply = 1'b1;
               cnt_in    = req_cycles;
               if (req_command == CMD_CYCLES && req_cycles != 4'd0) begin
                  state_in = ST_RUN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            cnt_in   = cnt_ff - 4'd1;
            if (cnt_ff == 4'd1) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.capture = 1'b1;
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.capture) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_no_accept_while_step: assert property (@(posedge clock) disable iff (reset)
      cmd.step |-> !req_ready)
      else $error("item accepted while divider is stepping");
   a_cycles_enter_run: assert property (@(posedge clock) disable iff (reset)
      (accept && req_command == CMD_CYCLES && req_cycles != 4'd0) |=> state_ff == ST_RUN)
      else $error("cycles item did not start stepping");
   a_capture_sets_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> rsp_valid_ff)
      else $error("result capture lost");
   a_one_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.apply, cmd.step, cmd.capture}))
      else $error("more than one datapath command");
`endif

endmodule

`default_nettype wire

FILE: src/wtsc_dp.sv
// datapath: channel registers, wave ram, divider, length counter, result register
`default_nettype none

module wtsc_dp (
   input  logic                  clock,
   input  logic                  reset,
   input  wtsc_pkg::ctl_cmd_type cmd,
   input  logic [2:0]            command,
   input  logic [2:0]            reg_select,
   input  logic [7:0]            write_data,
   input  logic [4:0]            ram_index,
   input  logic [3:0]            ram_sample,
   output logic [3:0]            sample_out,
   output logic                  channel_enabled
);
   import wtsc_pkg::*;

   logic              enabled_ff, enabled_in;
   logic              dac_on_ff, dac_on_in;
   logic [8:0]        length_ff, length_in;
   logic              len_en_ff, len_en_in;
   logic [10:0]       freq_ff, freq_in;
   logic [2:0]        vol_ff, vol_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [3:0]        buf_ff, buf_in;
   logic [12:0]       div_ff, div_in;
   logic [3:0]        wave_ram [WAVE_ENTRIES];
   logic [3:0]        sample_ff;
   logic              chan_en_ff;

   logic [12:0]       div_dec;
   logic [POS_W-1:0]  pos_inc;
   logic [10:0]       freq_hi_new;
   logic [3:0]        gated;
   logic [3:0]        shifted;

   assign div_dec     = (div_ff != 13'd0) ? div_ff - 13'd1 : div_ff;
   assign pos_inc     = (pos_ff == POS_W'(WAVE_ENTRIES - 1)) ? '0 : pos_ff + 1'b1;
   assign freq_hi_new = {write_data[2:0], freq_ff[7:0]};

   always_comb begin
      enabled_in = enabled_ff;
      dac_on_in  = dac_on_ff;
      length_in  = length_ff;
      len_en_in  = len_en_ff;
      freq_in    = freq_ff;
      vol_in     = vol_ff;
      pos_in     = pos_ff;
      buf_in     = buf_ff;
      div_in     = div_ff;
      if (cmd.apply) begin
         case (command)
            CMD_REG_WRITE: begin
               case (reg_select)
                  REG_DAC: begin
                     dac_on_in = write_data[7];
                     if (!write_data[7]) begin
                        enabled_in = 1'b0;
                     end
                  end
                  REG_LENGTH: begin
                     length_in = LEN_FULL - {1'b0, write_data};
                  end
                  REG_VOLUME: begin
                     // code 0 mutes, codes 1..3 shift by 0..2
                     vol_in = (write_data[6:5] != 2'd0) ?
                              {1'b0, write_data[6:5] - 2'd1} : VOL_MUTED;
                  end
                  REG_FREQ_LO: begin
                     freq_in = {freq_ff[10:8], write_data};
                  end
                  REG_FREQ_HI: begin
                     freq_in   = freq_hi_new;
                     len_en_in = write_data[6];
                     if (write_data[7]) begin
                        div_in = period_of(freq_hi_new);
                        if (length_ff == 9'd0) begin
                           length_in = LEN_FULL;
                        end
                        pos_in = '0;
                        if (dac_on_ff) begin
                           enabled_in = 1'b1;
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
            CMD_LENGTH: begin
               if (len_en_ff && length_ff != 9'd0) begin
                  length_in = length_ff - 9'd1;
                  if (length_ff == 9'd1) begin
                     enabled_in = 1'b0;
                  end
               end
            end
            CMD_POS_RESET: begin
               div_in = period_of(freq_ff);
               pos_in = '0;
            end
            default: begin
            end
         endcase
      end else if (cmd.step && enabled_ff) begin
         if (div_dec == 13'd0) begin
            pos_in = pos_inc;
            buf_in = wave_ram[pos_inc];
            div_in = period_of(freq_ff);
         end else begin
            div_in = div_dec;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         enabled_ff <= 1'b0;
         dac_on_ff  <= 1'b0;
         length_ff  <= 9'd0;
         len_en_ff  <= 1'b0;
         freq_ff    <= 11'd0;
         vol_ff     <= VOL_MUTED;
         pos_ff     <= '0;
         buf_ff     <= 4'd0;
         div_ff     <= DIV_RESET;
      end else begin
         enabled_ff <= enabled_in;
         dac_on_ff  <= dac_on_in;
         length_ff  <= length_in;
         len_en_ff  <= len_en_in;
         freq_ff    <= freq_in;
         vol_ff     <= vol_in;
         pos_ff     <= pos_in;
         buf_ff     <= buf_in;
         div_ff     <= div_in;
      end
   end

   // wave ram, cleared by reset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WAVE_ENTRIES; i++) begin
            wave_ram[i] <= 4'd0;
         end
      end else if (cmd.apply && command == CMD_RAM_WRITE &&
                   {1'b0, ram_index} < 6'(WAVE_ENTRIES)) begin
         wave_ram[ram_index[POS_W-1:0]] <= ram_sample;
      end
   end

   assign gated   = enabled_ff ? buf_ff : 4'd0;
   assign shifted = (vol_ff >= VOL_MUTED) ? 4'd0 : (gated >> vol_ff[1:0]);

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         sample_ff  <= shifted;
         chan_en_ff <= enabled_ff;
      end
   end

   assign sample_out      = sample_ff;
   assign channel_enabled = chan_en_ff;

endmodule

`default_nettype wire

FILE: src/wave_table_sound_channel.sv
// top level: wave-table sound channel, controller plus datapath
`default_nettype none

// Wave-table sound channel. Each request transfer carries one command: a
// channel register write, a count of elapsed input clocks, a length clock, a
// wave ram write or a position reset. Every request produces exactly one
// response transfer with the current sample (sample buffer shifted right by
// the volume, zero while the channel is off) and the enabled flag. Requests
// are handled one at a time. A cycles command steps the period divider by
// one input clock per cycle in the datapath, once for each clock that it
// counts, before the result register is loaded; every other command goes
// from its request transfer straight to the result load. Either load waits
// while an earlier response is still unaccepted. A finished response sits
// in an output register, so the next request is taken while it waits for the
// sink. The divider period is (2048 - frequency) * 2; on each divider tick the
// play position advances modulo the wave ram depth and the sample buffer
// reloads. The 32-entry wave ram and all channel state are cleared by reset.
module wave_table_sound_channel (
   input  logic       clock,
   input  logic       reset,
   wtsc_req_if.sink   req_if,
   wtsc_rsp_if.source rsp_if
);
   import wtsc_pkg::*;

   ctl_cmd_type cmd;

   // sequencing: idle, divider stepping, result hand-off
   wtsc_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_if.valid),
      .req_command (req_if.command),
      .req_cycles  (req_if.cycle_count),
      .req_ready   (req_if.ready),
      .rsp_valid   (rsp_if.valid),
      .rsp_ready   (rsp_if.ready),
      .cmd         (cmd)
   );

   // channel state and result register; item fields are read in the
   // transfer cycle only, when the apply command is issued
   wtsc_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .command         (req_if.command),
      .reg_select      (req_if.reg_select),
      .write_data      (req_if.write_data),
      .ram_index       (req_if.ram_index),
      .ram_sample      (req_if.ram_sample),
      .sample_out      (rsp_if.sample_out),
      .channel_enabled (rsp_if.channel_enabled)
   );

endmodule

`default_nettype wire
